// ===== hw/rtl/lswd_pkg.sv =====
// Package for the LIFO stack with remove-by-value.
// Holds action codes, controller states, the cell control word and width constants.
// No dependencies.
package lswd_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 16;
	localparam int ACT_W     = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SEEK = 1'b1
	} state_t;

	// Control word broadcast to every cell of the row
	typedef struct packed {
		logic push;     // shift toward the back, value enters cell 0
		logic pop;      // shift toward the front
		logic capture;  // register the per-cell match against the key
		logic squeeze;  // close the gap behind the first match
	} cell_ctl_t;

endpackage

// ===== hw/rtl/lswd_cell.sv =====
// One cell of the stack row: holds one word and its registered match flag.
// Cell 0 is the front. Depends on lswd_pkg.
module lswd_cell import lswd_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int INDEX = 0,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [CNT_W-1:0]  count,
	input  logic [DATA_W-1:0] key,
	input  logic [DATA_W-1:0] prev_data,
	input  logic [DATA_W-1:0] next_data,
	input  logic              hit_in,
	output logic              hit_out,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;
	logic              match_q;
	logic              occupied;

	assign occupied = CNT_W'(INDEX) < count;

	// A match at or in front of this cell moves this cell's word up by one
	assign hit_out = hit_in | match_q;
	assign data    = data_q;

	// Register the compare so the priority chain starts from flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.capture) begin
			match_q <= occupied && (data_q == key);
		end
	end

	// Advance the word along the row
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= prev_data;
		end else if (ctl.pop) begin
			data_q <= next_data;
		end else if (ctl.squeeze && hit_out) begin
			data_q <= next_data;
		end
	end

endmodule

// ===== hw/rtl/lswd_ctrl.sv =====
// Controller of the stack: command decode, entry count, result registers.
// Drives the control word of the cell row. Depends on lswd_pkg.
module lswd_ctrl import lswd_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACT_W-1:0]  action,
	input  logic [DATA_W-1:0] head_data,
	input  logic              hit_any,
	output logic              busy,
	output cell_ctl_t         ctl,
	output logic [CNT_W-1:0]  count,
	output logic              done,
	output logic [DATA_W-1:0] popped_value,
	output logic              found,
	output logic              overflow
);

	state_t            state_q, state_d;
	action_t           act;
	logic              accept;
	logic              full;
	logic              empty;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	logic [DATA_W-1:0] popped_q;
	logic              found_q;
	logic              ovf_q;

	assign act    = action_t'(action);
	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;
	assign accept = start && !busy;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && act == ACT_REMOVE) begin
					state_d = ST_SEEK;
				end
			end
			ST_SEEK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the state machine
	always_comb begin
		busy        = 1'b0;
		ctl         = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.push    = start && act == ACT_PUSH && !full;
				ctl.pop     = start && act == ACT_POP && !empty;
				ctl.capture = start && act == ACT_REMOVE;
			end
			ST_SEEK: begin
				busy        = 1'b1;
				ctl.squeeze = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Track the number of stored entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.squeeze) begin
			if (hit_any) begin
				count_q <= count_q - CNT_W'(1);
			end
		end else if (accept) begin
			case (act)
				ACT_PUSH:   if (!full) count_q <= count_q + CNT_W'(1);
				ACT_POP:    if (!empty) count_q <= count_q - CNT_W'(1);
				ACT_CLEAR:  count_q <= '0;
				default:    count_q <= count_q;
			endcase
		end
	end

	// Strobe the result in the cycle after the action completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && act != ACT_REMOVE) || ctl.squeeze;
		end
	end

	// Result word
	always_ff @(posedge clk) begin
		popped_q <= ctl.pop ? head_data : '0;
		found_q  <= ctl.squeeze && hit_any;
		ovf_q    <= accept && act == ACT_PUSH && full;
	end

	assign count        = count_q;
	assign done         = done_q;
	assign popped_value = popped_q;
	assign found        = found_q;
	assign overflow     = ovf_q;

	// A push, pop or clear gives its word in the next cycle
	a_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && act != ACT_REMOVE) |=> done_q)
		else $error("no result after single-cycle action");

	// A remove is busy while it searches, then strobes its word
	a_remove_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && act == ACT_REMOVE) |=> (busy && !done_q) ##1 (done_q && !busy))
		else $error("remove sequence broken");

	// A refused push leaves the stack full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ovf_q) |-> count_q == CNT_W'(DEPTH))
		else $error("overflow reported while not full");

	// A successful remove drops exactly one entry
	a_found_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove changed count wrongly");

	// A full stack stays full unless a clear, a pop or a remove intervenes
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		$past(full) && !$past(accept && act == ACT_CLEAR) && !$past(ctl.pop)
			&& !$past(ctl.squeeze) |-> full)
		else $error("count left full state without cause");

endmodule

// ===== hw/rtl/lifo_stack_with_delete.sv =====
// Top level of the LIFO stack with remove-by-value: a row of lswd_cell and lswd_ctrl.
// Depends on lswd_pkg, lswd_cell, lswd_ctrl.
//
// Bounded stack of DEPTH signed 32-bit words held in a row of cells, cell 0 the front.
// A command is taken when start is high and busy is low. Push, pop and clear complete
// without raising busy, so they may be issued back to back; the result word
// appears with done high in the cycle after the command. For a remove, first every
// cell registers its compare against value, then a priority chain through the row finds
// the first match from the front and the cells behind it move up one place. busy is high
// while the cells move up and done follows it. Each result word is shown for exactly one
// cycle with done and must be taken then; there is no back-pressure. entry_count is the
// number of words held after the command. A push into a full stack is dropped and flagged.
module lifo_stack_with_delete import lswd_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic signed [DATA_W-1:0] popped_value,
	output logic                     found,
	output logic                     overflow,
	output logic [CNT_W-1:0]         entry_count
);

	cell_ctl_t         ctl;
	logic [CNT_W-1:0]  count;
	logic [DATA_W-1:0] data [DEPTH];
	logic [DEPTH:0]    hit;
	logic [DATA_W-1:0] popped;

	assign hit[0] = 1'b0;

	// Row of cells, front to back
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] prev_data;
		logic [DATA_W-1:0] next_data;

		if (i == 0) begin : g_front
			assign prev_data = value;
		end else begin : g_inner
			assign prev_data = data[i-1];
		end

		if (i == DEPTH - 1) begin : g_back
			assign next_data = data[i];
		end else begin : g_mid
			assign next_data = data[i+1];
		end

		lswd_cell #(
			.DEPTH (DEPTH),
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (count),
			.key       (value),
			.prev_data (prev_data),
			.next_data (next_data),
			.hit_in    (hit[i]),
			.hit_out   (hit[i+1]),
			.data      (data[i])
		);
	end

	lswd_ctrl #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.head_data    (data[0]),
		.hit_any      (hit[DEPTH]),
		.busy         (busy),
		.ctl          (ctl),
		.count        (count),
		.done         (done),
		.popped_value (popped),
		.found        (found),
		.overflow     (overflow)
	);

	assign popped_value = popped;
	assign entry_count  = count;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lifo_stack_with_delete: a directed table, then random words.
// Every result word is checked against a queue-based stack predictor.
// Depends on lswd_pkg and the lifo_stack_with_delete RTL.
module tb;
	import lswd_pkg::*;

	localparam int DEPTH    = DEPTH_DEF;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int LIMIT    = 200000;
	localparam int DRAIN_CY = 8;
	localparam int DIR_N    = 21;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped;
		logic                     found;
		logic                     ovf;
		logic [CNT_W-1:0]         cnt;
	} stack_result_t;

	typedef struct packed {
		action_t                  act;
		logic signed [DATA_W-1:0] val;
		logic [4:0]               reps;
		logic                     typed;
		stack_result_t            res;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [ACT_W-1:0]         action;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic signed [DATA_W-1:0] popped_value;
	logic                     found;
	logic                     overflow;
	logic [CNT_W-1:0]         entry_count;

	logic signed [DATA_W-1:0] stack_model_q [$];   // index 0 bottom, last is front
	stack_result_t            expected_results_q [$];
	logic signed [DATA_W-1:0] value_pool [6];
	dir_row_t                 dir_tab [DIR_N];
	int                       err_cnt = 0;
	int                       cyc_cnt = 0;
	int                       idle_pct = 14;

	lifo_stack_with_delete u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.value        (value),
		.done         (done),
		.popped_value (popped_value),
		.found        (found),
		.overflow     (overflow),
		.entry_count  (entry_count)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Bound the run
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt >= LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cyc_cnt,
				expected_results_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Advance the stack model by one command and return the word it yields
	function automatic stack_result_t predict_result(input action_t act,
			input logic signed [DATA_W-1:0] val);
		stack_result_t r;
		int            i;
		r = '0;
		case (act)
			ACT_PUSH: begin
				if (stack_model_q.size() < DEPTH) stack_model_q.push_back(val);
				else r.ovf = 1'b1;
			end
			ACT_POP: begin
				if (stack_model_q.size() > 0) r.popped = stack_model_q.pop_back();
			end
			ACT_REMOVE: begin
				// search from the front, drop only the first match
				for (i = stack_model_q.size() - 1; i >= 0; i--) begin
					if (stack_model_q[i] === val) begin
						stack_model_q.delete(i);
						r.found = 1'b1;
						break;
					end
				end
			end
			default: stack_model_q.delete();
		endcase
		r.cnt = CNT_W'(stack_model_q.size());
		return r;
	endfunction

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && done) begin
			if (expected_results_q.size() == 0) begin
				report_mismatch($sformatf("result word with nothing expected (pop %h cnt %0d)",
					popped_value, entry_count));
			end else begin
				want = expected_results_q.pop_front();
				if (popped_value !== want.popped)
					report_mismatch($sformatf("popped_value %h, want %h", popped_value,
						want.popped));
				if (found !== want.found)
					report_mismatch($sformatf("found %b, want %b", found, want.found));
				if (overflow !== want.ovf)
					report_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
				if (entry_count !== want.cnt)
					report_mismatch($sformatf("entry_count %0d, want %0d", entry_count,
						want.cnt));
			end
		end
	end

	// Issue one command word and hold it until taken; drop start after it if asked
	task automatic send_word(input action_t act, input logic signed [DATA_W-1:0] val,
			input bit typed, input stack_result_t typed_res, input bit stop_after);
		stack_result_t r;
		start  <= 1'b1;
		action <= act;
		value  <= val;
		do @(posedge clk); while (busy);
		r = predict_result(act, val);
		if (typed) r = typed_res;
		expected_results_q.push_back(r);
		if (stop_after) begin
			start <= 1'b0;
		end else if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Hold off until every expected word has come back
	task automatic wait_drained();
		while (expected_results_q.size() != 0) @(posedge clk);
	endtask

	// Random words: mostly pool values so that removes hit, pushes biased per stretch
	task automatic run_phase(input int n_items);
		int                       k;
		int                       r;
		int                       push_pct;
		int                       pick;
		action_t                  act;
		logic signed [DATA_W-1:0] val;
		value_pool[0] = '0;
		value_pool[1] = -1;
		value_pool[2] = {1'b1, {(DATA_W-1){1'b0}}};
		value_pool[3] = {1'b0, {(DATA_W-1){1'b1}}};
		value_pool[4] = $urandom;
		value_pool[5] = $urandom_range(15);
		push_pct = 50;
		for (k = 0; k < n_items; k++) begin
			if (k % 40 == 0) push_pct = $urandom_range(75, 25);
			r = $urandom_range(99);
			if (r >= 96) act = ACT_CLEAR;
			else if (r < push_pct) act = ACT_PUSH;
			else if (r < push_pct + (96 - push_pct) / 2) act = ACT_POP;
			else act = ACT_REMOVE;
			pick = $urandom_range(99);
			if (act == ACT_REMOVE && pick < 40 && stack_model_q.size() > 0)
				val = stack_model_q[$urandom_range(stack_model_q.size() - 1)];
			else if (pick < 75 && act != ACT_POP && act != ACT_CLEAR)
				val = value_pool[$urandom_range(5)];
			else
				val = $urandom;
			send_word(act, val, 1'b0, '0, k == n_items - 1);
		end
	endtask

	// Stimulus
	initial begin
		int row;
		int rep;
		arst_n = 1'b0;
		start  = 1'b0;
		action = ACT_PUSH;
		value  = '0;

		// directed rows; a set typed bit means the expected word is given here
		dir_tab = '{
			'{ACT_POP,    32'sd0,        5'd1,  1'b1, '{32'sd0, 1'b0, 1'b0, 5'd0}},
			'{ACT_REMOVE, 32'sd5,        5'd1,  1'b1, '{32'sd0, 1'b0, 1'b0, 5'd0}},
			'{ACT_CLEAR,  32'sd0,        5'd1,  1'b1, '{32'sd0, 1'b0, 1'b0, 5'd0}},
			'{ACT_PUSH,   32'h7fffffff,  5'd1,  1'b1, '{32'sd0, 1'b0, 1'b0, 5'd1}},
			'{ACT_PUSH,   32'h80000000,  5'd1,  1'b1, '{32'sd0, 1'b0, 1'b0, 5'd2}},
			'{ACT_PUSH,   32'hffffffff,  5'd1,  1'b0, '0},
			'{ACT_PUSH,   32'sd0,        5'd1,  1'b0, '0},
			'{ACT_REMOVE, 32'h7ffffffe,  5'd1,  1'b0, '0},
			'{ACT_REMOVE, 32'h80000000,  5'd1,  1'b0, '0},
			'{ACT_POP,    32'h5a5a5a5a,  5'd1,  1'b0, '0},
			'{ACT_POP,    32'sd0,        5'd1,  1'b0, '0},
			'{ACT_POP,    32'sd0,        5'd1,  1'b0, '0},
			'{ACT_POP,    32'sd0,        5'd1,  1'b1, '{32'sd0, 1'b0, 1'b0, 5'd0}},
			'{ACT_PUSH,   32'sd3,        5'd16, 1'b0, '0},
			'{ACT_PUSH,   32'sd1234,     5'd1,  1'b1, '{32'sd0, 1'b0, 1'b1, 5'd16}},
			'{ACT_POP,    32'sd0,        5'd1,  1'b0, '0},
			'{ACT_PUSH,   32'sd42,       5'd1,  1'b0, '0},
			'{ACT_REMOVE, 32'sd3,        5'd1,  1'b0, '0},
			'{ACT_REMOVE, 32'sd42,       5'd1,  1'b0, '0},
			'{ACT_REMOVE, 32'sd42,       5'd1,  1'b0, '0},
			'{ACT_CLEAR,  32'hffffffff,  5'd1,  1'b1, '{32'sd0, 1'b0, 1'b0, 5'd0}}
		};

		// reset once, then release
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		for (row = 0; row < DIR_N; row++) begin
			for (rep = 0; rep < dir_tab[row].reps; rep++)
				send_word(dir_tab[row].act, dir_tab[row].val, dir_tab[row].typed,
					dir_tab[row].res, row == DIR_N - 1 && rep == dir_tab[row].reps - 1);
		end
		wait_drained();

		// sender idles lightly, then heavily, then never
		idle_pct = 14;
		run_phase(300);
		wait_drained();
		idle_pct = 69;
		run_phase(300);
		wait_drained();
		idle_pct = 0;
		run_phase(300);
		wait_drained();

		// let any stray word show up
		repeat (DRAIN_CY) @(posedge clk);
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
